// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Wrappers for concurrent checks; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication in the same cycle, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Check an implication in the next cycle, evaluated during reset too.
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, ante, cons)

`endif

`endif

// ===== rtl/dxt1_pkg.sv =====
// ---------------------------------------------------------------------------
// DXT1 decoder package
// Shared sizes, register indexes, transaction types and palette functions.
// ---------------------------------------------------------------------------
package dxt1_pkg;

   localparam int MAX_DIMENSION = 4096;

   // configuration register layout
   localparam int CFG_W = 13;
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // derived sizes
   localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
   localparam int COORD_W = $clog2(MAX_DIMENSION);
   localparam int BCNT_W  = $clog2((MAX_DIMENSION + 3) / 4 + 1);
   localparam int COL_RAW = $clog2((MAX_DIMENSION + 3) / 4);
   localparam int COL_W   = (COL_RAW < 1) ? 1 : COL_RAW;

   localparam int OUT_COORD_W = 12;
   localparam int CHAN_W      = 8;

   localparam int DESC_DEPTH = 2;
   localparam int OUT_DEPTH  = 2;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
   // reciprocal of three in 11 fractional bits
   localparam logic [9:0] RECIP3      = 10'd683;
   localparam int         RECIP3_SHIFT = 11;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } rgba_type;

   typedef rgba_type [3:0] palette_type;

   typedef struct packed {
      palette_type        pal;
      logic [31:0]        indices;
      logic [COORD_W-1:0] base_x;
      logic [COORD_W-1:0] base_y;
      logic [2:0]         ncols;
      logic [2:0]         nrows;
      logic               last_block;
   } desc_type;

   typedef struct packed {
      logic [OUT_COORD_W-1:0] pixel_x;
      logic [OUT_COORD_W-1:0] pixel_y;
      rgba_type               color;
      logic                   last_in_block;
      logic                   last_in_image;
   } pix_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // floor(x / 3) for x below 768
   function automatic logic [CHAN_W-1:0] div3(input logic [9:0] x);
      logic [19:0] prod;
      prod = x * RECIP3;
      return CHAN_W'(prod >> RECIP3_SHIFT);
   endfunction

   function automatic rgba_type widen565(input logic [15:0] c);
      rgba_type v;
      v.red   = {c[15:11], 3'b000};
      v.green = {c[10:5], 2'b00};
      v.blue  = {c[4:0], 3'b000};
      v.alpha = ALPHA_OPAQUE;
      return v;
   endfunction

   function automatic logic [CHAN_W-1:0] third(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
      logic [9:0] s;
      s = {1'b0, a, 1'b0} + {2'b00, b};
      return div3(s);
   endfunction

   function automatic logic [CHAN_W-1:0] half(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
      logic [CHAN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CHAN_W:1];
   endfunction

   function automatic palette_type decode_palette(input logic [15:0] c0,
                                                  input logic [15:0] c1);
      palette_type p;
      rgba_type    e0;
      rgba_type    e1;
      e0 = widen565(c0);
      e1 = widen565(c1);
      p[0] = e0;
      p[1] = e1;
      if (c0 > c1) begin
         p[2].red   = third(e0.red, e1.red);
         p[2].green = third(e0.green, e1.green);
         p[2].blue  = third(e0.blue, e1.blue);
         p[2].alpha = ALPHA_OPAQUE;
         p[3].red   = third(e1.red, e0.red);
         p[3].green = third(e1.green, e0.green);
         p[3].blue  = third(e1.blue, e0.blue);
         p[3].alpha = ALPHA_OPAQUE;
      end else begin
         p[2].red   = half(e0.red, e1.red);
         p[2].green = half(e0.green, e1.green);
         p[2].blue  = half(e0.blue, e1.blue);
         p[2].alpha = ALPHA_OPAQUE;
         p[3]       = '0;
      end
      return p;
   endfunction

endpackage

// ===== rtl/dxt1_desc_queue.sv =====
// ---------------------------------------------------------------------------
// DXT1 block descriptor queue
// Short register queue between the block front end and the pixel back end.
// ---------------------------------------------------------------------------
module dxt1_desc_queue import dxt1_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_data,
   input  logic             pop,
   output desc_type         head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DESC_DEPTH);
   localparam int CNT_W = $clog2(DESC_DEPTH + 1);

   desc_type               entry_ff [DESC_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DESC_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/dxt1_front.sv =====
// ---------------------------------------------------------------------------
// DXT1 block front end
// Holds the image size, tracks the block position, builds the palette and
// the visible extent of each block, and queues a descriptor for the back end.
// ---------------------------------------------------------------------------
module dxt1_front import dxt1_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_data,
   input  logic             accept,
   input  logic [63:0]      block_word,
   output logic             push,
   output desc_type         push_data
);

   logic [CFG_W-1:0]  width_ff, height_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  row_ff, row_in;

   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [DIM_W:0]    w_plus, h_plus;
   logic [BCNT_W-1:0] bx_count, by_count;
   logic [BCNT_W-1:0] col_inc, row_inc;
   logic [DIM_W:0]    rem_w, rem_h;
   logic              visible;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (32'(v) > MAX_DIMENSION) begin
         return DIM_W'(MAX_DIMENSION);
      end
      return DIM_W'(v);
   endfunction

   always_comb begin
      w_eff    = eff_dim(width_ff);
      h_eff    = eff_dim(height_ff);
      w_plus   = {1'b0, w_eff} + (DIM_W+1)'(3);
      h_plus   = {1'b0, h_eff} + (DIM_W+1)'(3);
      bx_count = BCNT_W'(w_plus >> 2);
      by_count = BCNT_W'(h_plus >> 2);
      col_inc  = BCNT_W'(col_ff) + BCNT_W'(1);
      row_inc  = BCNT_W'(row_ff) + BCNT_W'(1);
      visible  = (BCNT_W'(col_ff) < bx_count) && (BCNT_W'(row_ff) < by_count);

      push_data.pal        = decode_palette(block_word[15:0], block_word[31:16]);
      push_data.indices    = block_word[63:32];
      push_data.base_x     = COORD_W'({col_ff, 2'b00});
      push_data.base_y     = COORD_W'({row_ff, 2'b00});
      push_data.last_block = (col_inc == bx_count) && (row_inc == by_count);

      // columns and rows left inside the image, clipped to the block size
      rem_w = {1'b0, w_eff} - (DIM_W+1)'(push_data.base_x);
      rem_h = {1'b0, h_eff} - (DIM_W+1)'(push_data.base_y);
      push_data.ncols = (rem_w >= (DIM_W+1)'(4)) ? 3'd4 : rem_w[2:0];
      push_data.nrows = (rem_h >= (DIM_W+1)'(4)) ? 3'd4 : rem_h[2:0];

      // advance raster position, wrap at the end of a row and of the image
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= bx_count) begin
            col_in = '0;
            row_in = (row_inc >= by_count) ? '0 : COL_W'(row_inc);
         end else begin
            col_in = COL_W'(col_inc);
         end
      end
   end

   // blocks outside the image produce nothing
   assign push = accept && visible;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_write && csr_index == REG_IMAGE_WIDTH) begin
            width_ff <= csr_data;
         end
         if (csr_write && csr_index == REG_IMAGE_HEIGHT) begin
            height_ff <= csr_data;
         end
      end
   end

endmodule

// ===== rtl/dxt1_back.sv =====
// ---------------------------------------------------------------------------
// DXT1 pixel back end
// Walks the visible pixels of the head descriptor, one per cycle while the
// output queue has room, and holds finished pixels in a short output queue.
// ---------------------------------------------------------------------------
module dxt1_back import dxt1_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  desc_type         desc,
   input  queue_status_type desc_status,
   output logic             desc_pop,
   input  logic             out_pop,
   output pix_type          out_head,
   output logic             out_empty
);

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   logic [1:0]       px_ff, px_in;
   logic [1:0]       py_ff, py_in;
   pix_type          entry_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             fire;
   logic             row_end, col_end;
   logic [1:0]       ci;
   pix_type          pix;
   logic [COORD_W-1:0] x_full, y_full;

   always_comb begin
      fire    = !desc_status.empty && (count_ff != CNT_W'(OUT_DEPTH));
      col_end = ({1'b0, px_ff} == desc.ncols - 3'd1);
      row_end = ({1'b0, py_ff} == desc.nrows - 3'd1);
      ci      = desc.indices[{py_ff, px_ff, 1'b0} +: 2];
      x_full  = desc.base_x + COORD_W'(px_ff);
      y_full  = desc.base_y + COORD_W'(py_ff);

      pix.pixel_x       = OUT_COORD_W'(x_full);
      pix.pixel_y       = OUT_COORD_W'(y_full);
      pix.color         = desc.pal[ci];
      pix.last_in_block = col_end && row_end;
      pix.last_in_image = col_end && row_end && desc.last_block;

      desc_pop = fire && col_end && row_end;

      px_in = px_ff;
      py_in = py_ff;
      if (fire) begin
         if (col_end) begin
            px_in = '0;
            py_in = row_end ? 2'd0 : py_ff + 2'd1;
         end else begin
            px_in = px_ff + 2'd1;
         end
      end

      wr_ptr_in = fire    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = out_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(fire) - CNT_W'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff     <= '0;
         py_ff     <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         entry_ff[wr_ptr_ff] <= pix;
      end
   end

   assign out_head  = entry_ff[rd_ptr_ff];
   assign out_empty = (count_ff == '0);

endmodule

// ===== rtl/dxt1_block_decoder.sv =====
// ---------------------------------------------------------------------------
// DXT1 block decoder
// Decodes BC1 texture blocks in raster order into addressed RGBA pixels.
// ---------------------------------------------------------------------------
// Usage:
//  - Input queue: drive req_block_word and raise req_push; the transaction
//    is taken at an edge where req_full is low. One transaction is one
//    8-byte block, blocks in raster order across the image.
//  - Result queue: while rsp_empty is low the oldest pixel sits on the rsp_
//    ports; raise rsp_pop to take it. Up to sixteen pixels per block, row by
//    row, left to right; pixels beyond the image edge are dropped, and a
//    block wholly outside the image yields no pixel at all.
//  - Configuration: csr_write with csr_index 0 (width) or 1 (height) loads
//    csr_data at the edge. Write only while the decoder is idle.
//  - Flow: the first pixel of a block passes through the descriptor queue
//    and then the result queue before it reaches the rsp_ ports. Throughput is
//    one pixel per cycle while the result queue has room, set by the pixel
//    walker in the back end.
//  - A two-entry descriptor queue separates block classification from the
//    pixel walker, and a two-entry result queue absorbs a stalled receiver;
//    req_full rises whenever the descriptor queue holds two blocks.
//  - Reset clears both queues and the block position and sets the image
//    size to 4096 x 4096. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dxt1_block_decoder import dxt1_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [63:0]            req_block_word,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [OUT_COORD_W-1:0] rsp_pixel_x,
   output logic [OUT_COORD_W-1:0] rsp_pixel_y,
   output logic [CHAN_W-1:0]      rsp_red,
   output logic [CHAN_W-1:0]      rsp_green,
   output logic [CHAN_W-1:0]      rsp_blue,
   output logic [CHAN_W-1:0]      rsp_alpha,
   output logic                   rsp_last_in_block,
   output logic                   rsp_last_in_image,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   logic             req_accept;
   logic             desc_push;
   desc_type         desc_in;
   desc_type         desc_head;
   logic             desc_pop;
   queue_status_type desc_status;
   pix_type          out_head;
   logic             out_pop;

   // accept a block whenever the descriptor queue has room
   assign req_full   = desc_status.full;
   assign req_accept = req_push && !desc_status.full;

   // front: position, palette and clipping of each block
   dxt1_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (req_accept),
      .block_word (req_block_word),
      .push       (desc_push),
      .push_data  (desc_in)
   );

   // hold descriptors until the pixel walker is ready
   dxt1_desc_queue u_desc_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc_in),
      .pop       (desc_pop),
      .head      (desc_head),
      .status    (desc_status)
   );

   // back: walk pixels and buffer them for the receiver
   assign out_pop = rsp_pop && !rsp_empty;

   dxt1_back u_back (
      .clock       (clock),
      .reset       (reset),
      .desc        (desc_head),
      .desc_status (desc_status),
      .desc_pop    (desc_pop),
      .out_pop     (out_pop),
      .out_head    (out_head),
      .out_empty   (rsp_empty)
   );

   assign rsp_pixel_x       = out_head.pixel_x;
   assign rsp_pixel_y       = out_head.pixel_y;
   assign rsp_red           = out_head.color.red;
   assign rsp_green         = out_head.color.green;
   assign rsp_blue          = out_head.color.blue;
   assign rsp_alpha         = out_head.color.alpha;
   assign rsp_last_in_block = out_head.last_in_block;
   assign rsp_last_in_image = out_head.last_in_image;

   // end of image is always also end of block
   `ASSERT_IMPLIES(a_image_end_is_block_end, clock, reset, !rsp_empty && rsp_last_in_image, rsp_last_in_block)
   // never release a descriptor the walker does not hold
   `ASSERT_IMPLIES(a_desc_pop_valid, clock, reset, desc_pop, !desc_status.empty)
   // reset leaves the result queue empty and the descriptor queue not full
   `ASSERT_NEXT(a_reset_clears, clock, reset, rsp_empty && !req_full)

endmodule

// ===== tb/dxt1_block_decoder_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DXT1 block decoder checker
// Watches the block, size and pixel channels of the decoder and keeps its
// own copy of the image size and block position. Every block taken is
// decoded into the pixels it should yield. Every pixel popped is compared
// field by field with the oldest pixel still expected.
// ---------------------------------------------------------------------------
module dxt1_block_decoder_checker import dxt1_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  logic [63:0]            req_block_word,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  logic [OUT_COORD_W-1:0] rsp_pixel_x,
   input  logic [OUT_COORD_W-1:0] rsp_pixel_y,
   input  logic [CHAN_W-1:0]      rsp_red,
   input  logic [CHAN_W-1:0]      rsp_green,
   input  logic [CHAN_W-1:0]      rsp_blue,
   input  logic [CHAN_W-1:0]      rsp_alpha,
   input  logic                   rsp_last_in_block,
   input  logic                   rsp_last_in_image,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   output int                     error_count,
   output int                     pending_pixels,
   output int                     pixels_checked
);

   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   int unsigned      block_col;
   int unsigned      block_row;
   pix_type          expected_pixels[$];
   pix_type          want;

   // zero reads as one, anything past the maximum reads as the maximum
   function automatic int unsigned effective_dim(input logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return v;
   endfunction

   function automatic logic [CHAN_W-1:0] blend(input int unsigned a, input int unsigned b,
                                                input int unsigned wa, input int unsigned wb,
                                                input int unsigned div);
      return CHAN_W'((wa * a + wb * b) / div);
   endfunction

   function automatic void decode_block(input logic [63:0] word);
      int unsigned c0;
      int unsigned c1;
      int unsigned w;
      int unsigned h;
      int unsigned bx_count;
      int unsigned by_count;
      int unsigned x;
      int unsigned y;
      int unsigned n;
      int unsigned r0, g0, b0, r1, g1, b1;
      rgba_type    pal [4];
      pix_type     blk [16];
      logic [1:0]  ci;
      bit          final_block;
      c0 = word[15:0];
      c1 = word[31:16];
      w  = effective_dim(width_reg);
      h  = effective_dim(height_reg);
      bx_count = (w + 3) / 4;
      by_count = (h + 3) / 4;
      n = 0;
      // endpoints: plain left shift, no bit replication
      r0 = ((c0 >> 11) & 'h1F) << 3;
      g0 = ((c0 >> 5) & 'h3F) << 2;
      b0 = (c0 & 'h1F) << 3;
      r1 = ((c1 >> 11) & 'h1F) << 3;
      g1 = ((c1 >> 5) & 'h3F) << 2;
      b1 = (c1 & 'h1F) << 3;
      pal[0] = '{CHAN_W'(r0), CHAN_W'(g0), CHAN_W'(b0), ALPHA_OPAQUE};
      pal[1] = '{CHAN_W'(r1), CHAN_W'(g1), CHAN_W'(b1), ALPHA_OPAQUE};
      if (c0 > c1) begin
         pal[2] = '{blend(r0, r1, 2, 1, 3), blend(g0, g1, 2, 1, 3),
                    blend(b0, b1, 2, 1, 3), ALPHA_OPAQUE};
         pal[3] = '{blend(r0, r1, 1, 2, 3), blend(g0, g1, 1, 2, 3),
                    blend(b0, b1, 1, 2, 3), ALPHA_OPAQUE};
      end else begin
         pal[2] = '{blend(r0, r1, 1, 1, 2), blend(g0, g1, 1, 1, 2),
                    blend(b0, b1, 1, 1, 2), ALPHA_OPAQUE};
         pal[3] = '0;
      end
      final_block = (block_col + 1 == bx_count) && (block_row + 1 == by_count);
      if (block_col < bx_count && block_row < by_count) begin
         for (int py = 0; py < 4; py++) begin
            y = block_row * 4 + py;
            if (y < h) begin
               for (int px = 0; px < 4; px++) begin
                  x = block_col * 4 + px;
                  if (x < w) begin
                     ci = word[32 + 2 * (4 * py + px) +: 2];
                     blk[n].pixel_x       = OUT_COORD_W'(x);
                     blk[n].pixel_y       = OUT_COORD_W'(y);
                     blk[n].color         = pal[ci];
                     blk[n].last_in_block = 1'b0;
                     blk[n].last_in_image = 1'b0;
                     n++;
                  end
               end
            end
         end
         if (n > 0) begin
            blk[n-1].last_in_block = 1'b1;
            blk[n-1].last_in_image = final_block;
         end
         for (int i = 0; i < n; i++) expected_pixels = {expected_pixels, blk[i]};
      end
      block_col++;
      if (block_col >= bx_count) begin
         block_col = 0;
         block_row++;
         if (block_row >= by_count) block_row = 0;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned exp_val,
                                       input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg      = CFG_RESET;
         height_reg     = CFG_RESET;
         block_col      = 0;
         block_row      = 0;
         error_count    = 0;
         pixels_checked = 0;
         expected_pixels.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == REG_IMAGE_WIDTH) width_reg = csr_data;
            else height_reg = csr_data;
         end
         if (req_push && !req_full) decode_block(req_block_word);
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel with no expectation: x %0d y %0d", rsp_pixel_x, rsp_pixel_y);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_x", want.pixel_x, rsp_pixel_x);
               check_field("pixel_y", want.pixel_y, rsp_pixel_y);
               check_field("red", want.color.red, rsp_red);
               check_field("green", want.color.green, rsp_green);
               check_field("blue", want.color.blue, rsp_blue);
               check_field("alpha", want.color.alpha, rsp_alpha);
               check_field("last_in_block", want.last_in_block, rsp_last_in_block);
               check_field("last_in_image", want.last_in_image, rsp_last_in_image);
               pixels_checked++;
            end
         end
      end
      pending_pixels <= expected_pixels.size();
   end

endmodule

// ===== tb/dxt1_block_decoder_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DXT1 block decoder testbench
// Feeds directed and random BC1 blocks across a series of image sizes,
// including zero, oversized and mid-image size changes, with random idle
// bursts on both channels. A checker beside the decoder predicts and
// compares every pixel; this module only drives and gives the verdict.
// ---------------------------------------------------------------------------
module dxt1_block_decoder_tb import dxt1_pkg::*; ();

   localparam int LIMIT_CYCLES  = 2000000;
   localparam int SETTLE_CYCLES = 32;     // covers blocks that yield no pixel
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_ITEMS  = 390;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [63:0]            req_block_word = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [OUT_COORD_W-1:0] rsp_pixel_x;
   logic [OUT_COORD_W-1:0] rsp_pixel_y;
   logic [CHAN_W-1:0]      rsp_red;
   logic [CHAN_W-1:0]      rsp_green;
   logic [CHAN_W-1:0]      rsp_blue;
   logic [CHAN_W-1:0]      rsp_alpha;
   logic                   rsp_last_in_block;
   logic                   rsp_last_in_image;
   logic                   csr_write = 1'b0;
   logic                   csr_index = REG_IMAGE_WIDTH;
   logic [CFG_W-1:0]       csr_data = '0;

   int error_count;
   int pending_pixels;
   int pixels_checked;
   int cycle_count = 0;
   int blocks_sent = 0;
   int sizes_used  = 0;

   // idle controls for the sender and for the receiver
   bit tx_quiet     = 1'b0;
   bit rx_quiet     = 1'b0;
   bit rx_long_hold = 1'b0;

   always #6 clock = ~clock;

   dxt1_block_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_block_word    (req_block_word),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_last_in_block (rsp_last_in_block),
      .rsp_last_in_image (rsp_last_in_image),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   dxt1_block_decoder_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_block_word    (req_block_word),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_last_in_block (rsp_last_in_block),
      .rsp_last_in_image (rsp_last_in_image),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .error_count       (error_count),
      .pending_pixels    (pending_pixels),
      .pixels_checked    (pixels_checked)
   );

   // Watchdog: end the run as failed once the cycle limit is reached.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: pop by default, drop pop in random bursts, and hold off for
   // a long stretch when asked so the decoder backs up into req_full.
   // Every pass assigns rsp_pop once and then waits on the clock.
   initial begin : receiver
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rx_long_hold) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rx_long_hold = 1'b0;
         end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one block and hold it until the transaction is taken. The block
   // is accepted at the edge where req_full, sampled before the edge, was
   // low. Leave req_push high on return so back-to-back blocks need no
   // second assignment in the same step.
   task automatic send_block(input logic [63:0] word);
      int gap;
      if (!tx_quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 16);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_block_word <= word;
      do @(posedge clock); while (req_full);
      blocks_sent++;
   endtask

   // Stop offering and wait until every predicted pixel has been popped,
   // then let trailing blocks that yield no pixel clear the pipeline.
   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_pixels != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the width register, then the height register; call only when idle.
   task automatic set_image_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      csr_write <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_data  <= w;
      @(posedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_data  <= h;
      @(posedge clock);
      csr_write <= 1'b0;
      sizes_used++;
   endtask

   // Random block, steered toward each palette mode.
   function automatic logic [63:0] make_block();
      logic [63:0] word;
      logic [15:0] a;
      logic [15:0] b;
      word = {$urandom, $urandom};
      a = word[15:0];
      b = word[31:16];
      case ($urandom_range(0, 5))
         0: word[31:16] = a;                       // equal endpoints
         1: if (b > a) word[31:0] = {a, b};        // force color0 above color1
         2: if (b < a) word[31:0] = {a, b};        // force color0 below color1
         default: ;
      endcase
      return word;
   endfunction

   // Mostly small images so blocks clip and wrap often; now and then the
   // register extremes, including zero and values past the maximum.
   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return CFG_W'(1);
         2: return CFG_W'($urandom_range(2, 4));
         3, 4, 5, 6, 7: return CFG_W'($urandom_range(1, 24));
         8: return CFG_W'($urandom_range(25, 64));
         9: return CFG_W'(MAX_DIMENSION);
         10: return CFG_W'(MAX_DIMENSION + 1);
         default: return '1;
      endcase
   endfunction

   initial begin : stimulus
      int random_sent;
      int count;
      random_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset size, 4096 x 4096: every palette mode on full blocks.
      send_block(64'h0);                                    // equal black endpoints
      send_block('1);                                       // equal, all transparent
      send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF});      // four-color, every index
      send_block({32'h1B1B_1B1B, 16'hFFFF, 16'h0000});      // three-color, every index
      send_block({32'hFFFF_FFFF, 16'hF800, 16'h07E0});      // three-color, transparent
      send_block({32'hAAAA_AAAA, 16'h001F, 16'hF800});      // four-color, thirds only
      drain();

      // Zero size reads as 1 x 1: one pixel per block, each ends the image.
      set_image_size('0, '0);
      repeat (3) send_block(make_block());
      drain();

      // 6 x 5: clip on both edges and wrap past the last block.
      set_image_size(CFG_W'(6), CFG_W'(5));
      repeat (5) send_block(make_block());
      drain();

      // Shrink mid-image: the next block lies outside, yields nothing, and
      // the counters wrap into the next row; then shrink the height too.
      set_image_size(CFG_W'(16), CFG_W'(16));
      repeat (3) send_block(make_block());
      drain();
      set_image_size(CFG_W'(8), CFG_W'(16));
      repeat (2) send_block(make_block());
      drain();
      set_image_size(CFG_W'(8), CFG_W'(4));
      repeat (2) send_block(make_block());
      drain();

      // A few blocks at an oversized width and at an oversized height.
      set_image_size('1, CFG_W'(1));
      repeat (4) send_block(make_block());
      drain();
      set_image_size(CFG_W'(1), CFG_W'(5000));
      repeat (4) send_block(make_block());
      drain();

      // Long receiver hold-off while blocks keep coming: fill the queues.
      set_image_size(CFG_W'(64), CFG_W'(64));
      rx_long_hold = 1'b1;
      repeat (24) send_block(make_block());
      drain();

      // Random phases; the counters carry across size changes. Run the
      // tail with no idling on either side.
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= RANDOM_ITEMS - 60) begin
            tx_quiet = 1'b1;
            rx_quiet = 1'b1;
         end
         set_image_size(pick_dim(), pick_dim());
         count = $urandom_range(8, 40);
         repeat (count) send_block(make_block());
         random_sent += count;
         drain();
      end

      $display("Sent %0d blocks over %0d image sizes and checked %0d pixels,",
               blocks_sent, sizes_used, pixels_checked);
      $display("covering all palette modes, clipped and empty blocks and wraparound.");
      if (error_count == 0 && pending_pixels == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dxt1_pkg.sv
rtl/dxt1_desc_queue.sv
rtl/dxt1_front.sv
rtl/dxt1_back.sv
rtl/dxt1_block_decoder.sv
tb/dxt1_block_decoder_checker.sv
tb/dxt1_block_decoder_tb.sv
